// File: design/fxg3_pkg.sv
// Package for the Group 3 fax run-length decoder.
// Holds result kind codes, register indexes and the Modified Huffman table lookup;
// no dependencies.
package fxg3_pkg;

  localparam logic [2:0] KIND_WHITE = 3'd0;
  localparam logic [2:0] KIND_BLACK = 3'd1;
  localparam logic [2:0] KIND_EOL   = 3'd2;
  localparam logic [2:0] KIND_EOD   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MSB_FIRST = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_EMPTY_LIM = 2'd2;

  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_TERM   = 2'd1;
  localparam logic [1:0] CLS_MAKEUP = 2'd2;

  typedef struct packed {
    logic [1:0]  cls;
    logic [12:0] val;
  } match_t;

  typedef logic [15:0] tab64_t [64];
  typedef logic [15:0] tab27_t [27];
  typedef logic [15:0] tab13_t [13];

  // Entries hold {length[3:0], code[11:0]}; codes never exceed 12 bits wide except
  // 13-bit black makeups, whose top bit is zero, so 12 code bits suffice.
  localparam tab64_t WT = '{
    16'h8035,16'h6007,16'h4007,16'h4008,16'h400b,16'h400c,16'h400e,16'h400f,
    16'h5013,16'h5014,16'h5007,16'h5008,16'h6008,16'h6003,16'h6034,16'h6035,
    16'h602a,16'h602b,16'h7027,16'h700c,16'h7008,16'h7017,16'h7003,16'h7004,
    16'h7028,16'h702b,16'h7013,16'h7024,16'h7018,16'h8002,16'h8003,16'h801a,
    16'h801b,16'h8012,16'h8013,16'h8014,16'h8015,16'h8016,16'h8017,16'h8028,
    16'h8029,16'h802a,16'h802b,16'h802c,16'h802d,16'h8004,16'h8005,16'h800a,
    16'h800b,16'h8052,16'h8053,16'h8054,16'h8055,16'h8024,16'h8025,16'h8058,
    16'h8059,16'h805a,16'h805b,16'h804a,16'h804b,16'h8032,16'h8033,16'h8034};
  localparam tab64_t BT = '{
    16'ha037,16'h3002,16'h2003,16'h2002,16'h3003,16'h4003,16'h4002,16'h5003,
    16'h6005,16'h6004,16'h7004,16'h7005,16'h7007,16'h8004,16'h8007,16'h9018,
    16'ha017,16'ha018,16'ha008,16'hb067,16'hb068,16'hb06c,16'hb037,16'hb028,
    16'hb017,16'hb018,16'hc0ca,16'hc0cb,16'hc0cc,16'hc0cd,16'hc068,16'hc069,
    16'hc06a,16'hc06b,16'hc0d2,16'hc0d3,16'hc0d4,16'hc0d5,16'hc0d6,16'hc0d7,
    16'hc06c,16'hc06d,16'hc0da,16'hc0db,16'hc054,16'hc055,16'hc056,16'hc057,
    16'hc064,16'hc065,16'hc052,16'hc053,16'hc024,16'hc037,16'hc038,16'hc027,
    16'hc028,16'hc058,16'hc059,16'hc02b,16'hc02c,16'hc05a,16'hc066,16'hc067};
  localparam tab27_t WM = '{
    16'h501b,16'h5012,16'h6017,16'h7037,16'h8036,16'h8037,16'h8064,16'h8065,
    16'h8068,16'h8067,16'h90cc,16'h90cd,16'h90d2,16'h90d3,16'h90d4,16'h90d5,
    16'h90d6,16'h90d7,16'h90d8,16'h90d9,16'h90da,16'h90db,16'h9098,16'h9099,
    16'h909a,16'h6018,16'h909b};
  localparam tab27_t BM = '{
    16'ha00f,16'hc0c8,16'hc0c9,16'hc05b,16'hc033,16'hc034,16'hc035,16'hd06c,
    16'hd06d,16'hd04a,16'hd04b,16'hd04c,16'hd04d,16'hd072,16'hd073,16'hd074,
    16'hd075,16'hd076,16'hd077,16'hd052,16'hd053,16'hd054,16'hd055,16'hd05a,
    16'hd05b,16'hd064,16'hd065};
  localparam tab13_t EX = '{
    16'hb008,16'hb00c,16'hb00d,16'hc012,16'hc013,16'hc014,16'hc015,16'hc016,
    16'hc017,16'hc01c,16'hc01d,16'hc01e,16'hc01f};

  // Matches one codeword of the given length against the tables of one color and the shared extended makeups.
  function automatic match_t classify(input logic black, input logic [3:0] len,
                                      input logic [12:0] code);
    match_t m;
    logic [15:0] key;
    m = '{cls: CLS_NONE, val: '0};
    key = {len, code[11:0]};
    if (code[12] == 1'b0) begin
      for (int i = 63; i >= 0; i--) begin
        if ((black ? BT[i] : WT[i]) == key) begin
          m = '{cls: CLS_TERM, val: 13'(i)};
        end
      end
      if (m.cls == CLS_NONE) begin
        for (int i = 26; i >= 0; i--) begin
          if ((black ? BM[i] : WM[i]) == key) begin
            m = '{cls: CLS_MAKEUP, val: 13'((i + 1) * 64)};
          end
        end
      end
      if (m.cls == CLS_NONE) begin
        for (int i = 12; i >= 0; i--) begin
          if (EX[i] == key) begin
            m = '{cls: CLS_MAKEUP, val: 13'(1792 + 64 * i)};
          end
        end
      end
    end
    return m;
  endfunction

endpackage

// File: design/fax_g3_run_length_decoder.sv
// Top level of the Group 3 fax run-length decoder: bit-serial codeword matcher.
// Depends on fxg3_pkg for kind codes, register indexes and the Modified Huffman tables.
//
// Each accepted byte beat is loaded into a shift register and decoded one bit
// per clock, unless a result waits on a full output register; the next byte
// is accepted only once every bit of the current one is decoded. A result is
// held back so that its last flag is known: it moves to the output register
// when the next result of the same byte appears, or when the byte ends, and
// that final move shares its edge with the acceptance of the next byte. A bit
// that produces a result while another is held waits as long as the output
// register is still full, so every consumer stall there delays the byte.
// Every bit depends on the codeword, color and column state left by the
// previous bit, which is what sets the one-bit-per-cycle pace. Results come
// out in bit order, with last set on the final result of a byte; a byte that
// yields nothing produces no beat. After the document ends every later byte
// is accepted and dropped.
module fax_g3_run_length_decoder #(
  parameter int COLUMN_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [11:0] run_start,
  output logic [11:0] run_length,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import fxg3_pkg::*;

  localparam logic [12:0] COL_MAX = 13'((1 << COLUMN_BITS) - 1);

  logic        msb_first;
  logic [11:0] width_limit;
  logic [2:0]  empty_line_limit;

  logic [7:0]  shift;
  logic [3:0]  bits_left;
  logic [12:0] code_bits;
  logic [3:0]  code_length;
  logic [3:0]  zero_run;
  logic        line_color_black;
  logic [12:0] pending_count;
  logic [12:0] column;
  logic [2:0]  empty_line_count;
  logic        document_ended;
  logic        resyncing;

  // The result held back until it is known whether another one follows.
  logic        have_result;
  logic [2:0]  hold_kind;
  logic [11:0] hold_start;
  logic [11:0] hold_length;

  // Handshake and sequencing terms.
  logic        out_free, byte_done, flush, step;

  // Per-bit decode, all in combinational form, taken by the registers below.
  logic        b, eol, emit;
  logic [3:0]  zr_n, cl_n;
  logic [12:0] cb_shift;
  logic [12:0] lim, room, tot;
  logic [13:0] sum;
  logic [2:0]  k_n;
  logic [11:0] rs_n, rl_n;
  logic [2:0]  elc_inc;
  match_t      m;

  // The output register can take a new beat when empty or when it is being read.
  assign out_free  = !out_valid || out_ready;
  assign byte_done = (bits_left == 4'd0) || document_ended;
  assign flush     = byte_done && have_result && out_free;
  assign step      = (bits_left != 4'd0) && !document_ended &&
                     !(emit && have_result && !out_free);
  assign in_ready  = (bits_left == 4'd0) && (!have_result || out_free);
  assign b = msb_first ? shift[7] : shift[0];

  always_comb begin
    eol      = (zero_run >= 4'd11) && b;
    zr_n     = b ? 4'd0 : ((zero_run < 4'd15) ? zero_run + 4'd1 : 4'd15);
    cl_n     = (code_length < 4'd15) ? code_length + 4'd1 : 4'd15;
    cb_shift = {code_bits[11:0], b};
    m        = classify(line_color_black, cl_n, cb_shift);
    lim      = ({1'b0, width_limit} > COL_MAX) ? COL_MAX : {1'b0, width_limit};
    room     = lim - column;
    sum      = {1'b0, pending_count} + {1'b0, m.val};
    tot      = (sum > {1'b0, room}) ? room : sum[12:0];
    elc_inc  = (empty_line_count < 3'd7) ? empty_line_count + 3'd1 : 3'd7;
    emit     = 1'b0;
    k_n      = KIND_ERROR;
    rs_n     = '0;
    rl_n     = '0;
    if (!resyncing) begin
      if (eol) begin
        emit = 1'b1;
        if (column == '0) begin
          k_n = (elc_inc >= empty_line_limit) ? KIND_EOD : KIND_EOL;
        end else begin
          k_n  = KIND_EOL;
          rl_n = column[11:0];
        end
      end else if (cb_shift != '0) begin
        if (cl_n > 4'd13) begin
          emit = 1'b1;
        end else if (m.cls == CLS_TERM) begin
          if (column >= lim) begin
            emit = 1'b1;
          end else if (tot != '0) begin
            emit = 1'b1;
            k_n  = line_color_black ? KIND_BLACK : KIND_WHITE;
            rs_n = column[11:0];
            rl_n = tot[11:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first        <= 1'b1;
      width_limit      <= 12'd2550;
      empty_line_limit <= 3'd5;
      bits_left        <= '0;
      code_bits        <= '0;
      code_length      <= '0;
      zero_run         <= '0;
      line_color_black <= 1'b0;
      pending_count    <= '0;
      column           <= '0;
      empty_line_count <= '0;
      document_ended   <= 1'b0;
      resyncing        <= 1'b0;
      have_result      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MSB_FIRST: msb_first <= cfg_data[0];
          REG_WIDTH:     width_limit <= cfg_data;
          REG_EMPTY_LIM: empty_line_limit <= cfg_data[2:0];
          default: ;
        endcase
      end

      // The held result goes out at the end of its byte with last set, or
      // earlier without last when the next result of the byte replaces it.
      if (flush || (step && emit && have_result)) begin
        out_valid  <= 1'b1;
        kind       <= hold_kind;
        run_start  <= hold_start;
        run_length <= hold_length;
        last       <= flush;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (step && emit) begin
        have_result <= 1'b1;
        hold_kind   <= k_n;
        hold_start  <= rs_n;
        hold_length <= rl_n;
      end else if (flush) begin
        have_result <= 1'b0;
      end

      if (in_valid && in_ready) begin
        shift     <= data_byte;
        bits_left <= document_ended ? 4'd0 : 4'd8;
      end else if (step) begin
        shift     <= msb_first ? {shift[6:0], 1'b0} : {1'b0, shift[7:1]};
        bits_left <= bits_left - 4'd1;
      end else if (document_ended) begin
        bits_left <= 4'd0;
      end

      if (step) begin
        zero_run <= zr_n;
        if (resyncing) begin
          if (eol) begin
            resyncing <= 1'b0;
            code_bits <= '0; code_length <= '0; line_color_black <= 1'b0;
            pending_count <= '0; column <= '0;
          end
        end else if (eol) begin
          code_bits <= '0; code_length <= '0; line_color_black <= 1'b0;
          pending_count <= '0; column <= '0;
          if (column == '0) begin
            empty_line_count <= elc_inc;
            if (elc_inc >= empty_line_limit) document_ended <= 1'b1;
          end else begin
            empty_line_count <= '0;
          end
        end else if (cb_shift == '0) begin
          code_length <= cl_n;
          code_bits   <= cb_shift;
        end else if (cl_n > 4'd13) begin
          code_length <= cl_n;
          code_bits   <= cb_shift;
          resyncing   <= 1'b1;
        end else if (m.cls == CLS_MAKEUP) begin
          code_bits <= '0; code_length <= '0;
          pending_count <= sum[13] ? 13'h1fff : sum[12:0];
        end else if (m.cls == CLS_TERM) begin
          code_bits <= '0; code_length <= '0;
          if (column >= lim) begin
            resyncing <= 1'b1;
          end else begin
            pending_count    <= '0;
            line_color_black <= !line_color_black;
            column           <= column + tot;
          end
        end else begin
          code_length <= cl_n;
          code_bits   <= cb_shift;
        end
      end
    end
  end

endmodule
